FILE: rtl/frs_pkg.sv
// Shared types, constants and helpers for the float stream reduce block.
`timescale 1ns / 1ps
package frs_pkg;

    // Reduction kinds, as written into the operation register
    localparam logic [2:0] OP_MAX  = 3'd0;
    localparam logic [2:0] OP_MIN  = 3'd1;
    localparam logic [2:0] OP_SUM  = 3'd2;
    localparam logic [2:0] OP_MEAN = 3'd3;
    localparam logic [2:0] OP_PROD = 3'd4;

    // Float32 constants
    localparam logic [31:0] FP_ZERO   = 32'h0000_0000;
    localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    // Request into the shared float unit
    typedef struct packed {
        logic        start;
        logic        is_mul;
        logic [31:0] a;
        logic [31:0] b;
    } fpu_req_t;

    // Response from the shared float unit
    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } fpu_rsp_t;

    function automatic logic is_nan(input logic [31:0] x);
        return (&x[30:23]) && (|x[22:0]);
    endfunction

    // Ordering key: unsigned compare of keys matches float order, -0 below +0
    function automatic logic [31:0] order_key(input logic [31:0] x);
        return x[31] ? ~x : (x | 32'h8000_0000);
    endfunction

    // maxNum / minNum: a NaN yields the other operand
    function automatic logic [31:0] pick(input logic [31:0] a, input logic [31:0] b,
                                         input logic want_max);
        logic [31:0] ka;
        logic [31:0] kb;
        logic [31:0] r;
        ka = order_key(a);
        kb = order_key(b);
        if (is_nan(a) && is_nan(b)) begin
            r = CANON_NAN;
        end else if (is_nan(a)) begin
            r = b;
        end else if (is_nan(b)) begin
            r = a;
        end else if (want_max) begin
            r = (ka >= kb) ? a : b;
        end else begin
            r = (ka <= kb) ? a : b;
        end
        return r;
    endfunction

endpackage

FILE: rtl/frs_recip.sv
// Iterative float32 reciprocal of an integer length, one quotient bit per cycle.
`timescale 1ns / 1ps
module frs_recip (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] len,
    output logic        done,
    output logic [31:0] recip
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_RND} state_t;

    state_t      state_reg, state_next;
    logic [17:0] rem_reg, rem_next;
    logic [24:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [3:0]  k_reg, k_next;
    logic [15:0] len_reg, len_next;
    logic        done_reg, done_next;
    logic [31:0] res_reg, res_next;

    // Position of the leading one of the length
    logic [3:0] lead;
    logic       pow2;
    always_comb begin
        lead = '0;
        for (int i = 0; i < 16; i++) begin
            if (len[i]) lead = 4'(i);
        end
        pow2 = ((len & (len - 16'd1)) == 16'd0);
    end

    // Divider step and final rounding
    logic        ge;
    logic [17:0] sub;
    logic [23:0] mant;
    logic        up;
    logic [24:0] m25;
    logic [7:0]  expo;
    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        len_next   = len_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        ge   = rem_reg >= {2'b0, len_reg};
        sub  = ge ? (rem_reg - {2'b0, len_reg}) : rem_reg;
        mant = quo_reg[24:1];
        up   = quo_reg[0] & ((|rem_reg) | mant[0]);
        m25  = {1'b0, mant} + {24'b0, up};
        expo = 8'd126 - {4'b0, k_reg};
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    if (pow2) begin
                        res_next  = {1'b0, 8'd127 - {4'b0, lead}, 23'b0};
                        done_next = 1'b1;
                    end else begin
                        rem_next   = 18'd1 << ({1'b0, lead} + 5'd1);
                        quo_next   = '0;
                        cnt_next   = '0;
                        k_next     = lead;
                        len_next   = len;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                quo_next = {quo_reg[23:0], ge};
                rem_next = {sub[16:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd24) state_next = S_RND;
            end
            S_RND: begin
                if (m25[24]) begin
                    res_next = {1'b0, expo + 8'd1, 23'b0};
                end else begin
                    res_next = {1'b0, expo, m25[22:0]};
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        k_reg   <= k_next;
        len_reg <= len_next;
        res_reg <= res_next;
    end

    assign done  = done_reg;
    assign recip = res_reg;

endmodule

FILE: rtl/frs_fpu.sv
// Shared float32 add / multiply unit: prepare, normalize loop, round to nearest even.
`timescale 1ns / 1ps
module frs_fpu (
    input  logic             aclk,
    input  logic             aresetn,
    input  frs_pkg::fpu_req_t req,
    output frs_pkg::fpu_rsp_t rsp
);

    typedef enum logic [1:0] {S_IDLE, S_PREP, S_NORM, S_ROUND} state_t;

    state_t             state_reg, state_next;
    logic [31:0]        a_reg, a_next;
    logic [31:0]        b_reg, b_next;
    logic               mul_reg, mul_next;
    logic [47:0]        w_reg, w_next;
    logic signed [10:0] x_reg, x_next;
    logic               stk_reg, stk_next;
    logic               sign_reg, sign_next;
    logic               zsign_reg, zsign_next;
    logic [31:0]        res_reg, res_next;
    logic               done_reg, done_next;

    // Operand unpack
    logic        sa, sb;
    logic [7:0]  ea, eb, eae, ebe;
    logic [23:0] ma, mb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    always_comb begin
        sa     = a_reg[31];
        sb     = b_reg[31];
        ea     = a_reg[30:23];
        eb     = b_reg[30:23];
        eae    = (ea == 8'd0) ? 8'd1 : ea;
        ebe    = (eb == 8'd0) ? 8'd1 : eb;
        ma     = {|ea, a_reg[22:0]};
        mb     = {|eb, b_reg[22:0]};
        nan_a  = frs_pkg::is_nan(a_reg);
        nan_b  = frs_pkg::is_nan(b_reg);
        inf_a  = (&ea) && !(|a_reg[22:0]);
        inf_b  = (&eb) && !(|b_reg[22:0]);
        zero_a = !(|a_reg[30:0]);
        zero_b = !(|b_reg[30:0]);
    end

    // Multiply path: one 24x24 product, registered into the work word
    logic [47:0]        prod;
    logic signed [10:0] x_mul;
    assign prod  = ma * mb;
    assign x_mul = $signed({3'b0, eae}) + $signed({3'b0, ebe}) - 11'sd126;

    // Add path: order by magnitude, align smaller operand with sticky
    logic        a_big;
    logic        s_big;
    logic [7:0]  e_big, e_sml, dexp;
    logic [23:0] m_big, m_sml;
    logic [53:0] ext;
    logic [26:0] al, al_s;
    logic        st;
    logic [27:0] sum;
    always_comb begin
        a_big = a_reg[30:0] >= b_reg[30:0];
        s_big = a_big ? sa : sb;
        e_big = a_big ? eae : ebe;
        e_sml = a_big ? ebe : eae;
        m_big = a_big ? ma : mb;
        m_sml = a_big ? mb : ma;
        dexp  = e_big - e_sml;
        ext   = {m_sml, 30'b0} >> dexp;
        if (dexp >= 8'd27) begin
            al = '0;
            st = |m_sml;
        end else begin
            al = ext[53:27];
            st = |ext[26:0];
        end
        al_s = {al[26:1], al[0] | st};
        if (sa == sb) begin
            sum = {1'b0, m_big, 3'b0} + {1'b0, al_s};
        end else begin
            sum = {1'b0, m_big, 3'b0} - {1'b0, al_s};
        end
    end

    // Denormalizing right shift
    logic signed [10:0] nsh;
    logic [95:0]        rsh;
    always_comb begin
        nsh = 11'sd1 - x_reg;
        rsh = {w_reg, 48'b0} >> nsh[6:0];
    end

    // Rounding
    logic [23:0]        rm;
    logic               rup;
    logic [24:0]        rm25;
    logic signed [10:0] xr;
    logic [23:0]        mfin;
    logic               sfin;
    always_comb begin
        rm   = w_reg[47:24];
        rup  = w_reg[23] & ((|w_reg[22:0]) | stk_reg | rm[0]);
        rm25 = {1'b0, rm} + {24'b0, rup};
        if (rm25[24]) begin
            mfin = rm25[24:1];
            xr   = x_reg + 11'sd1;
        end else begin
            mfin = rm25[23:0];
            xr   = x_reg;
        end
        sfin = (mfin == 24'd0) ? zsign_reg : sign_reg;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        mul_next   = mul_reg;
        w_next     = w_reg;
        x_next     = x_reg;
        stk_next   = stk_reg;
        sign_next  = sign_reg;
        zsign_next = zsign_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    a_next     = req.a;
                    b_next     = req.b;
                    mul_next   = req.is_mul;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                stk_next   = 1'b0;
                state_next = S_NORM;
                if (mul_reg) begin
                    sign_next  = sa ^ sb;
                    zsign_next = sa ^ sb;
                    w_next     = prod;
                    x_next     = x_mul;
                    if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
                        res_next   = frs_pkg::CANON_NAN;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end else if (inf_a || inf_b) begin
                        res_next   = {sa ^ sb, 8'hFF, 23'b0};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end else if (zero_a || zero_b) begin
                        res_next   = {sa ^ sb, 31'b0};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    sign_next  = s_big;
                    zsign_next = sa & sb;
                    w_next     = {sum, 20'b0};
                    x_next     = $signed({3'b0, e_big}) + 11'sd1;
                    if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
                        res_next   = frs_pkg::CANON_NAN;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end else if (inf_a) begin
                        res_next   = a_reg;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end else if (inf_b) begin
                        res_next   = b_reg;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_NORM: begin
                priority if (x_reg < 11'sd1) begin
                    if (nsh >= 11'sd48) begin
                        w_next   = '0;
                        stk_next = stk_reg | (|w_reg);
                    end else begin
                        w_next   = rsh[95:48];
                        stk_next = stk_reg | (|rsh[47:0]);
                    end
                    x_next     = 11'sd1;
                    state_next = S_ROUND;
                end else if (!w_reg[47] && x_reg > 11'sd1) begin
                    priority if (w_reg[47:32] == 16'd0 && x_reg > 11'sd16) begin
                        w_next = {w_reg[31:0], 16'b0};
                        x_next = x_reg - 11'sd16;
                    end else if (w_reg[47:44] == 4'd0 && x_reg > 11'sd4) begin
                        w_next = {w_reg[43:0], 4'b0};
                        x_next = x_reg - 11'sd4;
                    end else begin
                        w_next = {w_reg[46:0], 1'b0};
                        x_next = x_reg - 11'sd1;
                    end
                end else begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                if (xr > 11'sd254) begin
                    res_next = {sign_reg, 8'hFF, 23'b0};
                end else begin
                    res_next = {sfin, mfin[23] ? xr[7:0] : 8'd0, mfin[22:0]};
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        a_reg     <= a_next;
        b_reg     <= b_next;
        mul_reg   <= mul_next;
        w_reg     <= w_next;
        x_reg     <= x_next;
        stk_reg   <= stk_next;
        sign_reg  <= sign_next;
        zsign_reg <= zsign_next;
        res_reg   <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

FILE: rtl/float_stream_reduce_core.sv
// Top level: float32 stream reduction (max, min, sum, mean, product) per group.
// One element is taken at a time. Max and min fold an item straight into the result register,
// then close. Sum and product go through the shared float add/multiply unit: prepare, then
// one normalize shift step at a time, then round (the unit ends at prepare when an operand is
// NaN, infinite or, for product, zero); the shift steps grow with cancellation or subnormal
// operands. Closing a mean group adds a reciprocal of the length (through the one-bit-per-cycle
// divider, with no divide steps for a power of two) and one more multiply. The result sits in
// an output register, and the next element is taken while it waits; the next group's result
// stalls the block until that register is free.
`timescale 1ns / 1ps
module float_stream_reduce_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_element,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_reduced_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [15:0] LEN_MASK =
        (LENGTH_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << LENGTH_BITS) - 32'd1);

    localparam logic REG_OPERATION = 1'b0;
    localparam logic REG_LENGTH    = 1'b1;

    typedef enum logic [2:0] {ST_IDLE, ST_WAIT, ST_CLOSE, ST_RECIP, ST_MEAN, ST_OUT}
        state_t;

    state_t      state_reg;
    logic [2:0]  operation_reg;
    logic [15:0] length_reg;
    logic [31:0] acc_reg;
    logic [15:0] count_reg;
    logic [2:0]  op_reg;
    logic [15:0] len_reg;
    logic [15:0] cnt_reg;
    logic [31:0] res_reg;
    logic        m_valid_reg;
    logic [31:0] m_data_reg;

    // Configuration port
    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LENGTH) ? {16'b0, length_reg} : {29'b0, operation_reg};

    // Item decode at accept
    logic        accept;
    logic        first;
    logic        is_arith;
    logic        is_mul;
    logic [15:0] len_masked;
    logic [15:0] len_eff;
    assign accept     = s_valid & s_ready;
    assign first      = (count_reg == 16'd0);
    assign is_mul     = (operation_reg == frs_pkg::OP_PROD);
    assign is_arith   = (operation_reg == frs_pkg::OP_SUM) ||
                        (operation_reg == frs_pkg::OP_MEAN) || is_mul;
    assign len_masked = length_reg & LEN_MASK;
    assign len_eff    = (len_masked == 16'd0) ? 16'd1 : len_masked;

    // Shared float unit and reciprocal divider
    frs_pkg::fpu_req_t fpu_req;
    frs_pkg::fpu_rsp_t fpu_rsp;
    logic              recip_start;
    logic              recip_done;
    logic [31:0]       recip_val;

    always_comb begin
        if (state_reg == ST_RECIP) begin
            fpu_req.start  = recip_done;
            fpu_req.is_mul = 1'b1;
            fpu_req.a      = res_reg;
            fpu_req.b      = recip_val;
        end else begin
            fpu_req.start  = accept & is_arith;
            fpu_req.is_mul = is_mul;
            fpu_req.a      = first ? (is_mul ? frs_pkg::FP_ONE : frs_pkg::FP_ZERO) : acc_reg;
            fpu_req.b      = s_element;
        end
    end

    frs_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .rsp     (fpu_rsp)
    );

    logic group_done;
    assign group_done  = (cnt_reg >= len_reg) || (cnt_reg == 16'd0);
    assign recip_start = (state_reg == ST_CLOSE) && group_done &&
                         (op_reg == frs_pkg::OP_MEAN);

    frs_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (recip_start),
        .len     (len_reg),
        .done    (recip_done),
        .recip   (recip_val)
    );

    // Sequencer, accumulator and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            operation_reg <= frs_pkg::OP_MAX;
            length_reg    <= 16'd1;
            acc_reg       <= frs_pkg::FP_ZERO;
            count_reg     <= 16'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_OPERATION) operation_reg <= pwdata[2:0];
                else                           length_reg    <= pwdata[15:0];
            end
            // ST_OUT handles the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_OUT) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        op_reg  <= operation_reg;
                        len_reg <= len_eff;
                        cnt_reg <= count_reg + 16'd1;
                        if (is_arith) begin
                            state_reg <= ST_WAIT;
                        end else begin
                            res_reg   <= frs_pkg::pick(first ? s_element : acc_reg, s_element,
                                                       operation_reg != frs_pkg::OP_MIN);
                            state_reg <= ST_CLOSE;
                        end
                    end
                end
                ST_WAIT: begin
                    if (fpu_rsp.done) begin
                        res_reg   <= fpu_rsp.result;
                        state_reg <= ST_CLOSE;
                    end
                end
                ST_CLOSE: begin
                    if (group_done) begin
                        acc_reg   <= frs_pkg::FP_ZERO;
                        count_reg <= 16'd0;
                        state_reg <= (op_reg == frs_pkg::OP_MEAN) ? ST_RECIP : ST_OUT;
                    end else begin
                        acc_reg   <= res_reg;
                        count_reg <= cnt_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RECIP: begin
                    if (recip_done) state_reg <= ST_MEAN;
                end
                ST_MEAN: begin
                    if (fpu_rsp.done) begin
                        res_reg   <= fpu_rsp.result;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_reduced_value = m_data_reg;

    // Checks
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("element taken while previous still in work");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output step");

    a_fpu_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        fpu_rsp.done |-> (state_reg == ST_WAIT || state_reg == ST_MEAN))
        else $error("float unit finished with no request pending");

endmodule

FILE: bench/float_stream_reduce_core_tb.sv
// Self-checking bench for the float stream reduce core: predicts each group result and checks it.
`timescale 1ns / 1ps
module float_stream_reduce_core_tb;

    localparam logic [2:0] REG_OPERATION = 3'd0;
    localparam logic [2:0] REG_LENGTH    = 3'd4;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 80;
    localparam int ITEM_TARGET   = 2000;
    localparam int QUIET_FROM    = 1700;

    // Group reduction predictor and store of expected group results
    class reduce_scoreboard;
        logic [2:0]  cur_op;
        logic [15:0] group_len;
        logic [31:0] running;
        logic [15:0] taken;
        logic [31:0] expected_values[$];
        int          errors;

        function new();
            cur_op    = frs_pkg::OP_MAX;
            group_len = 16'd1;
            running   = frs_pkg::FP_ZERO;
            taken     = 16'd0;
            errors    = 0;
        endfunction

        function void report(input string what, input logic [31:0] got, input logic [31:0] want);
            $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
            errors++;
        endfunction

        function logic nan_bits(input logic [31:0] x);
            return (x[30:23] == 8'hff) && (x[22:0] != 0);
        endfunction

        function logic inf_bits(input logic [31:0] x);
            return (x[30:23] == 8'hff) && (x[22:0] == 0);
        endfunction

        // value = mant * 2^expo
        function void unpack(input logic [31:0] x, output logic sgn, output logic [95:0] mant,
                             output int expo);
            sgn = x[31];
            if (x[30:23] == 0) begin
                mant = {73'd0, x[22:0]};
                expo = -149;
            end else begin
                mant = {72'd0, 1'b1, x[22:0]};
                expo = int'(x[30:23]) - 150;
            end
        endfunction

        // Round mant * 2^expo to float32, nearest even, with subnormals and overflow
        function logic [31:0] round_pack(input logic sgn, input logic [95:0] mant, input int expo);
            int lead, lsb, sh;
            logic [95:0] q, rem, half;
            if (mant == 0) return {sgn, 31'd0};
            lead = 95;
            while (!mant[lead]) lead--;
            lsb = expo + lead - 23;
            if (lsb < -149) lsb = -149;
            sh = lsb - expo;
            if (sh <= 0) begin
                q = mant << (-sh);
            end else if (sh >= 90) begin
                q = 0;
            end else begin
                q    = mant >> sh;
                rem  = mant & ((96'd1 << sh) - 96'd1);
                half = 96'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0])) q = q + 96'd1;
            end
            if (q[24]) begin
                q = q >> 1;
                lsb++;
            end
            if (!q[23]) return {sgn, 8'd0, q[22:0]};
            if (lsb + 150 >= 255) return {sgn, 8'hff, 23'd0};
            return {sgn, 8'(lsb + 150), q[22:0]};
        endfunction

        function logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
            logic sa, sb_, sr;
            logic [95:0] ma, mb, wa, wb, sum, tmp_m;
            int ea, eb, d, tmp_e;
            logic tmp_s;
            if (nan_bits(a) || nan_bits(b)) return frs_pkg::CANON_NAN;
            if (inf_bits(a) && inf_bits(b) && a[31] != b[31]) return frs_pkg::CANON_NAN;
            if (inf_bits(a)) return a;
            if (inf_bits(b)) return b;
            unpack(a, sa, ma, ea);
            unpack(b, sb_, mb, eb);
            if (ma == 0 && mb == 0) return {sa & sb_, 31'd0};
            if (ma == 0) return b;
            if (mb == 0) return a;
            if (ea < eb) begin
                tmp_s = sa; sa = sb_; sb_ = tmp_s;
                tmp_m = ma; ma = mb; mb = tmp_m;
                tmp_e = ea; ea = eb; eb = tmp_e;
            end
            d  = ea - eb;
            wa = ma << 42;
            if (d > 66) begin
                wb = 96'd1;
            end else begin
                wb = (mb << 42) >> d;
                if (((mb << 42) & ((96'd1 << d) - 96'd1)) != 0) wb[0] = 1'b1;
            end
            if (sa == sb_) begin
                sum = wa + wb;
                sr  = sa;
            end else if (wa >= wb) begin
                sum = wa - wb;
                sr  = sa;
            end else begin
                sum = wb - wa;
                sr  = sb_;
            end
            if (sum == 0) return frs_pkg::FP_ZERO;
            return round_pack(sr, sum, ea - 42);
        endfunction

        function logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
            logic sa, sb_;
            logic [95:0] ma, mb;
            int ea, eb;
            if (nan_bits(a) || nan_bits(b)) return frs_pkg::CANON_NAN;
            if (inf_bits(a) || inf_bits(b)) begin
                if (a[30:0] == 0 || b[30:0] == 0) return frs_pkg::CANON_NAN;
                return {a[31] ^ b[31], 8'hff, 23'd0};
            end
            unpack(a, sa, ma, ea);
            unpack(b, sb_, mb, eb);
            return round_pack(sa ^ sb_, ma * mb, ea + eb);
        endfunction

        // Rounded float32 of 1/len
        function logic [31:0] reciprocal(input logic [15:0] len);
            logic [95:0] q;
            q = (96'd1 << 60) / len;
            q = (q << 1) | (((96'd1 << 60) % len) != 0);
            return round_pack(1'b0, q, -61);
        endfunction

        // maxNum/minNum, -0 below +0
        function logic [31:0] select(input logic [31:0] a, input logic [31:0] b, input logic want_max);
            logic [31:0] ka, kb;
            if (nan_bits(a) && nan_bits(b)) return frs_pkg::CANON_NAN;
            if (nan_bits(a)) return b;
            if (nan_bits(b)) return a;
            ka = a[31] ? ~a : (a | 32'h8000_0000);
            kb = b[31] ? ~b : (b | 32'h8000_0000);
            if (want_max) return (ka >= kb) ? a : b;
            return (ka <= kb) ? a : b;
        endfunction

        // Fold one accepted element in; queue a result when its group closes
        function void note_element(input logic [31:0] e);
            logic [15:0] len;
            logic        first;
            logic [31:0] res;
            len   = (group_len == 0) ? 16'd1 : group_len;
            first = (taken == 0);
            case (cur_op)
                frs_pkg::OP_SUM, frs_pkg::OP_MEAN:
                    running = fadd(first ? frs_pkg::FP_ZERO : running, e);
                frs_pkg::OP_PROD:
                    running = fmul(first ? frs_pkg::FP_ONE : running, e);
                default:
                    running = select(first ? e : running, e, cur_op != frs_pkg::OP_MIN);
            endcase
            taken = taken + 16'd1;
            if (taken >= len || taken == 0) begin
                res = running;
                if (cur_op == frs_pkg::OP_MEAN) res = fmul(running, reciprocal(len));
                expected_values.push_back(res);
                running = frs_pkg::FP_ZERO;
                taken   = 16'd0;
            end
        endfunction

        function void check_result(input logic [31:0] got);
            logic [31:0] want;
            if (expected_values.size() == 0) begin
                $display("MISMATCH unexpected result %h at %0t", got, $realtime);
                errors++;
                return;
            end
            want = expected_values.pop_front();
            if (got !== want) report("reduced_value", got, want);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_element;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_reduced_value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    reduce_scoreboard sb = new();
    bit idle_on;
    bit long_hold_req;
    int items_sent;
    int stall_cycles = 0;

    float_stream_reduce_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element       (s_element),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reduced_value (m_reduced_value),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Clock
    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Watchdog: cycles with no traffic anywhere
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable) || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("float_stream_reduce_core_tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Receiver: checks results, stalls in bursts, one long hold on request
    initial begin : receiver
        int hold;
        hold = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_reduced_value);
            if (long_hold_req) begin
                long_hold_req = 0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 11) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_read_check(input logic [2:0] addr, input logic [31:0] want);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) sb.report("register readback", prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stop sending, let all expected results arrive, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_values.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [2:0] op, input logic [15:0] len);
        drain();
        reg_write(REG_OPERATION, {29'd0, op});
        reg_write(REG_LENGTH, {16'd0, len});
        reg_read_check(REG_OPERATION, {29'd0, op});
        reg_read_check(REG_LENGTH, {16'd0, len});
        sb.cur_op    = op;
        sb.group_len = len;
    endtask

    // Offer one item and hold it until accepted, then maybe idle a burst
    task automatic send_element(input logic [31:0] e);
        s_valid   <= 1'b1;
        s_element <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_element(e);
        items_sent++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    task automatic send_list(input logic [31:0] elems[$]);
        foreach (elems[k]) send_element(elems[k]);
    endtask

    function automatic logic [31:0] rand_element();
        logic [31:0] specials[12] = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000,
                                      32'hff80_0000, 32'h7fc0_0000, 32'hffc0_0001,
                                      32'h7f7f_ffff, 32'hff7f_ffff, 32'h0000_0001,
                                      32'h8000_0001, 32'h3f80_0000, 32'hbf80_0000};
        case ($urandom_range(0, 9))
            0:       return specials[$urandom_range(0, 11)];
            1:       return {1'($urandom), 8'd0, 23'($urandom)};
            2, 3:    return $urandom;
            default: return {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)};
        endcase
    endfunction

    // Main sequence
    initial begin : stimulus
        logic [2:0]  op;
        logic [15:0] len;
        int          n;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_element     = 32'd0;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        items_sent    = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings, then special values per operation
        send_list('{32'h4040_0000});
        configure(frs_pkg::OP_SUM, 16'd2);
        send_list('{32'h7f80_0000, 32'hff80_0000, 32'h3f80_0000, 32'hbf80_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h7f7f_ffff, 32'h7f7f_ffff,
                    32'h0000_0001, 32'h007f_ffff, 32'h7fc0_0000, 32'h3f80_0000});
        configure(frs_pkg::OP_PROD, 16'd2);
        send_list('{32'h0000_0000, 32'hff80_0000, 32'h7f7f_ffff, 32'h4000_0000,
                    32'h0000_0001, 32'h3f00_0000});
        configure(frs_pkg::OP_MAX, 16'd2);
        send_list('{32'hffc0_0001, 32'h3f80_0000, 32'h8000_0000, 32'h0000_0000});
        configure(frs_pkg::OP_MIN, 16'd2);
        send_list('{32'h0000_0000, 32'h8000_0000, 32'h7fc0_0000, 32'hffc0_0001});
        configure(frs_pkg::OP_MEAN, 16'd3);
        send_list('{32'h3f80_0000, 32'h4000_0000, 32'h4040_0000});
        // Zero length acts as one; unused code behaves as max
        configure(3'd7, 16'd0);
        send_list('{32'hc000_0000, 32'h7f80_0000});
        // Longest length, then shortened mid-group
        configure(frs_pkg::OP_SUM, 16'hffff);
        send_list('{32'h3f80_0000, 32'h4000_0000, 32'h4040_0000});
        configure(frs_pkg::OP_MEAN, 16'd2);
        send_list('{32'h4080_0000});

        // Receiver holds off for a long stretch while items keep coming
        configure(frs_pkg::OP_SUM, 16'd1);
        long_hold_req = 1'b1;
        repeat (40) send_element(rand_element());

        // Random settings and groups
        while (items_sent < ITEM_TARGET) begin
            op = 3'($urandom_range(0, 9));
            if (op > 3'd4 && $urandom_range(0, 3) != 0) op = 3'($urandom_range(0, 4));
            case ($urandom_range(0, 19))
                0:       len = 16'd0;
                1:       len = 16'($urandom_range(17, 64));
                default: len = 16'($urandom_range(1, 8));
            endcase
            configure(op, len);
            if (items_sent >= QUIET_FROM) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 3) != 0);
            n = ((len == 0) ? 1 : len) * $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, 3);
            repeat (n) send_element(rand_element());
        end

        s_valid <= 1'b0;
        while (sb.expected_values.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("float_stream_reduce_core_tb: done, clean");
        end else begin
            $display("float_stream_reduce_core_tb: done, errors");
        end
        $finish;
    end

endmodule
